/* rtl/core/idalloc_pkg.sv */
package idalloc_pkg;

  localparam int ID_W = 11;
  localparam int ST_W = 2;

  localparam logic [ID_W-1:0] ID_LIMIT_RST = 11'd1024;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_HEAP_FULL = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RA_ROOT,
    RA_LAST,
    RA_PARENT,
    RA_LEFT,
    RA_RIGHT
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WD_VAL,
    WD_RD,
    WD_LVAL
  } wdata_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_ZERO,
    POS_COUNT,
    POS_PARENT,
    POS_LEFT,
    POS_RIGHT
  } pos_sel_t;

  typedef enum logic [1:0] {
    VAL_HOLD,
    VAL_RID,
    VAL_RD
  } val_sel_t;

  typedef enum logic [1:0] {
    RID_ZERO,
    RID_RD,
    RID_FRESH
  } res_id_sel_t;

  typedef struct packed {
    logic        load_req;
    raddr_sel_t  raddr_sel;
    logic        we;
    wdata_sel_t  wdata_sel;
    pos_sel_t    pos_sel;
    val_sel_t    val_sel;
    logic        lval_load;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        issue_inc;
    logic        res_load;
    res_id_sel_t res_id_sel;
    status_t     res_status;
    logic        out_load;
  } cmd_t;

  typedef struct packed {
    logic req_recycle;
    logic heap_empty;
    logic heap_full;
    logic exhausted;
    logic id_invalid;
    logic has_left;
    logic has_right;
    logic at_root;
    logic rd_lt_val;
    logic rd_gt_val;
    logic lval_lt_val;
    logic right_wins;
  } stat_t;

endpackage

/* rtl/core/idalloc_ifs.sv */
interface idalloc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [idalloc_pkg::ID_W-1:0] recycled_id;

  modport source (output valid, output req_type, output recycled_id, input ready);
  modport sink (input valid, input req_type, input recycled_id, output ready);
endinterface

interface idalloc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [idalloc_pkg::ID_W-1:0] granted_id;
  logic [idalloc_pkg::ST_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink (input valid, input granted_id, input status, output ready);
endinterface

/* rtl/core/idalloc_dp.sv */
module idalloc_dp #(
  parameter int MAX_IDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [idalloc_pkg::ID_W-1:0]  cfg_wr_data,
  input  logic                          in_req_type,
  input  logic [idalloc_pkg::ID_W-1:0]  in_recycled_id,
  input  idalloc_pkg::cmd_t             cmd,
  output idalloc_pkg::stat_t            stat,
  output logic [idalloc_pkg::ID_W-1:0]  out_granted_id,
  output logic [idalloc_pkg::ST_W-1:0]  out_status
);

  localparam int AW    = $clog2(MAX_IDS);
  localparam int CNT_W = $clog2(MAX_IDS + 1);
  localparam int ID_W  = idalloc_pkg::ID_W;
  localparam logic [31:0]      MAX_W   = 32'(MAX_IDS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);

  logic [ID_W-1:0]  mem [MAX_IDS];
  logic [ID_W-1:0]  rd_data_r;
  logic [AW-1:0]    raddr;
  logic [ID_W-1:0]  wdata;

  logic [CNT_W-1:0] heap_count_r;
  logic [ID_W-1:0]  issued_count_r;
  logic [ID_W-1:0]  id_limit_r;

  logic [AW-1:0]    pos_r;
  logic [AW-1:0]    pos_nxt;
  logic [ID_W-1:0]  val_r;
  logic [ID_W-1:0]  lval_r;
  logic             req_type_r;
  logic [ID_W-1:0]  rid_r;
  logic [ID_W-1:0]  res_id_r;
  idalloc_pkg::status_t res_status_r;
  logic [ID_W-1:0]  out_granted_r;
  idalloc_pkg::status_t out_status_r;

  logic [AW+1:0]    left_w;
  logic [AW+1:0]    right_w;
  logic [AW+1:0]    cnt_w;
  logic [AW-1:0]    parent;
  logic [CNT_W-1:0] last_c;
  logic [31:0]      lim_c;
  logic [ID_W-1:0]  best_c;

  assign left_w  = {1'b0, pos_r, 1'b1};
  assign right_w = left_w + (AW+2)'(1);
  assign cnt_w   = (AW+2)'(heap_count_r);
  assign parent  = AW'((pos_r - AW'(1)) >> 1);
  assign last_c  = heap_count_r - CNT_W'(1);
  assign lim_c   = (32'(id_limit_r) > MAX_W) ? MAX_W : 32'(id_limit_r);
  assign best_c  = (lval_r < val_r) ? lval_r : val_r;

  always_comb begin
    stat.req_recycle = req_type_r;
    stat.heap_empty  = (heap_count_r == '0);
    stat.heap_full   = (heap_count_r == MAX_CNT);
    stat.exhausted   = (32'(issued_count_r) >= lim_c);
    stat.id_invalid  = (rid_r == '0) || (rid_r > issued_count_r);
    stat.has_left    = (left_w < cnt_w);
    stat.has_right   = (right_w < cnt_w);
    stat.at_root     = (pos_r == '0);
    stat.rd_lt_val   = (rd_data_r < val_r);
    stat.rd_gt_val   = (rd_data_r > val_r);
    stat.lval_lt_val = (lval_r < val_r);
    stat.right_wins  = (rd_data_r < best_c);
  end

  always_comb begin
    case (cmd.raddr_sel)
      idalloc_pkg::RA_ROOT:   raddr = '0;
      idalloc_pkg::RA_LAST:   raddr = last_c[AW-1:0];
      idalloc_pkg::RA_PARENT: raddr = parent;
      idalloc_pkg::RA_LEFT:   raddr = left_w[AW-1:0];
      idalloc_pkg::RA_RIGHT:  raddr = right_w[AW-1:0];
      default:                raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wdata_sel)
      idalloc_pkg::WD_VAL:  wdata = val_r;
      idalloc_pkg::WD_RD:   wdata = rd_data_r;
      idalloc_pkg::WD_LVAL: wdata = lval_r;
      default:              wdata = val_r;
    endcase
  end

  always_comb begin
    case (cmd.pos_sel)
      idalloc_pkg::POS_HOLD:   pos_nxt = pos_r;
      idalloc_pkg::POS_ZERO:   pos_nxt = '0;
      idalloc_pkg::POS_COUNT:  pos_nxt = heap_count_r[AW-1:0];
      idalloc_pkg::POS_PARENT: pos_nxt = parent;
      idalloc_pkg::POS_LEFT:   pos_nxt = left_w[AW-1:0];
      idalloc_pkg::POS_RIGHT:  pos_nxt = right_w[AW-1:0];
      default:                 pos_nxt = pos_r;
    endcase
  end

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
    if (cmd.we) begin
      mem[pos_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_count_r   <= '0;
      issued_count_r <= '0;
      id_limit_r     <= idalloc_pkg::ID_LIMIT_RST;
    end else begin
      if (cfg_wr_en) begin
        id_limit_r <= cfg_wr_data;
      end
      if (cmd.cnt_inc) begin
        heap_count_r <= heap_count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        heap_count_r <= last_c;
      end
      if (cmd.issue_inc) begin
        issued_count_r <= issued_count_r + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      rid_r      <= in_recycled_id;
    end
    case (cmd.val_sel)
      idalloc_pkg::VAL_RID: val_r <= rid_r;
      idalloc_pkg::VAL_RD:  val_r <= rd_data_r;
      default:              val_r <= val_r;
    endcase
    if (cmd.lval_load) begin
      lval_r <= rd_data_r;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_id_sel)
        idalloc_pkg::RID_RD:    res_id_r <= rd_data_r;
        idalloc_pkg::RID_FRESH: res_id_r <= issued_count_r + ID_W'(1);
        default:                res_id_r <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_granted_r <= res_id_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_granted_id = out_granted_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_count_r <= MAX_CNT)
    else $error("heap count above capacity");

  a_issued_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(issued_count_r) <= MAX_W)
    else $error("issued count above capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.we && heap_count_r != '0 |-> 32'(pos_r) < 32'(heap_count_r))
    else $error("heap write outside occupied range");

  a_issue_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && issued_count_r != $past(issued_count_r) |->
      issued_count_r == $past(issued_count_r) + ID_W'(1))
    else $error("issued count moved by more than one");
`endif

endmodule

/* rtl/core/idalloc_ctrl.sv */
module idalloc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  idalloc_pkg::stat_t stat,
  output idalloc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_POP_TOP,
    S_POP_LAST,
    S_SD_CHK,
    S_SD_L,
    S_SD_R,
    S_PU_CHK,
    S_PU_CMP,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_load = 1'b1;
        if (!stat.req_recycle) begin
          if (!stat.heap_empty) begin
            cmd.raddr_sel = idalloc_pkg::RA_ROOT;
            cmd.res_load  = 1'b0;
            state_nxt     = S_POP_TOP;
          end else if (stat.exhausted) begin
            cmd.res_status = idalloc_pkg::ST_EXHAUSTED;
            state_nxt      = S_OUT;
          end else begin
            cmd.issue_inc  = 1'b1;
            cmd.res_id_sel = idalloc_pkg::RID_FRESH;
            state_nxt      = S_OUT;
          end
        end else if (stat.id_invalid) begin
          cmd.res_status = idalloc_pkg::ST_INVALID;
          state_nxt      = S_OUT;
        end else if (stat.heap_full) begin
          cmd.res_status = idalloc_pkg::ST_HEAP_FULL;
          state_nxt      = S_OUT;
        end else begin
          cmd.val_sel = idalloc_pkg::VAL_RID;
          cmd.pos_sel = idalloc_pkg::POS_COUNT;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_PU_CHK;
        end
      end
      S_POP_TOP: begin
        cmd.res_load   = 1'b1;
        cmd.res_id_sel = idalloc_pkg::RID_RD;
        cmd.raddr_sel  = idalloc_pkg::RA_LAST;
        cmd.cnt_dec    = 1'b1;
        state_nxt      = S_POP_LAST;
      end
      S_POP_LAST: begin
        cmd.val_sel = idalloc_pkg::VAL_RD;
        cmd.pos_sel = idalloc_pkg::POS_ZERO;
        state_nxt   = S_SD_CHK;
      end
      S_SD_CHK: begin
        if (stat.has_left) begin
          cmd.raddr_sel = idalloc_pkg::RA_LEFT;
          state_nxt     = S_SD_L;
        end else begin
          cmd.we    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SD_L: begin
        cmd.lval_load = 1'b1;
        if (stat.has_right) begin
          cmd.raddr_sel = idalloc_pkg::RA_RIGHT;
          state_nxt     = S_SD_R;
        end else if (stat.rd_lt_val) begin
          cmd.we        = 1'b1;
          cmd.wdata_sel = idalloc_pkg::WD_RD;
          cmd.pos_sel   = idalloc_pkg::POS_LEFT;
          state_nxt     = S_SD_CHK;
        end else begin
          cmd.we    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SD_R: begin
        cmd.we = 1'b1;
        if (stat.right_wins) begin
          cmd.wdata_sel = idalloc_pkg::WD_RD;
          cmd.pos_sel   = idalloc_pkg::POS_RIGHT;
          state_nxt     = S_SD_CHK;
        end else if (stat.lval_lt_val) begin
          cmd.wdata_sel = idalloc_pkg::WD_LVAL;
          cmd.pos_sel   = idalloc_pkg::POS_LEFT;
          state_nxt     = S_SD_CHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_PU_CHK: begin
        if (stat.at_root) begin
          cmd.we    = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.raddr_sel = idalloc_pkg::RA_PARENT;
          state_nxt     = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        cmd.we = 1'b1;
        if (stat.rd_gt_val) begin
          cmd.wdata_sel = idalloc_pkg::WD_RD;
          cmd.pos_sel   = idalloc_pkg::POS_PARENT;
          state_nxt     = S_PU_CHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/id_allocator_min_heap.sv */
// Identifier allocator. An allocate transfer returns the smallest recycled
// identifier held in a min-heap, or, with the heap empty, the next fresh one
// from a counter that stops at min(id_limit, MAX_IDS) and then reports
// exhaustion. A recycle transfer pushes a valid identifier into the heap;
// zero or an identifier never issued gives status invalid, a full heap gives
// heap full. Items are handled one at a time by a controller that walks the
// heap in a memory with one registered read and one write per cycle. Fresh
// allocations and rejected recycles are resolved in the dispatch state; a
// push climbs the heap one parent compare per level, and a pop reads the top
// and the last entry, then sifts down one level per child compare, stopping
// at a node with no smaller child. The input side is ready again in the
// cycle after the result is loaded. The result register frees the input
// side while a result waits. Duplicate recycles are not detected. id_limit
// may only be written while idle.
module id_allocator_min_heap #(
  parameter int MAX_IDS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [idalloc_pkg::ID_W-1:0] cfg_wr_data,
  idalloc_req_if.sink                  in_req,
  idalloc_rsp_if.source                out_rsp
);

  idalloc_pkg::cmd_t  cmd;
  idalloc_pkg::stat_t stat;

  idalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  idalloc_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_req_type    (in_req.req_type),
    .in_recycled_id (in_req.recycled_id),
    .cmd            (cmd),
    .stat           (stat),
    .out_granted_id (out_rsp.granted_id),
    .out_status     (out_rsp.status)
  );

endmodule

/* bench/tb_id_allocator_min_heap.sv */
module tb_id_allocator_min_heap;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W = idalloc_pkg::ID_W;
  localparam int ST_W = idalloc_pkg::ST_W;
  localparam int HEAP_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int LONG_HOLD = 600;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_RECYCLE = 1'b1;
  localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

  class id_pool_scoreboard;
    typedef struct {
      logic [ID_W-1:0]      id;
      idalloc_pkg::status_t st;
    } grant_t;

    logic [ID_W-1:0] slots [0:HEAP_DEPTH-1];
    int              heap_cnt;
    int              issued;
    int              limit;
    int              errors;
    grant_t          pending_grants[$];

    function new();
      heap_cnt = 0;
      issued = 0;
      limit = int'(idalloc_pkg::ID_LIMIT_RST);
      errors = 0;
    endfunction

    function void set_limit(logic [ID_W-1:0] v);
      limit = int'(v);
    endfunction

    function logic [ID_W-1:0] take_min();
      logic [ID_W-1:0] top;
      logic [ID_W-1:0] t;
      int pos, l, r, pick;
      top = slots[0];
      heap_cnt--;
      slots[0] = slots[heap_cnt];
      pos = 0;
      while (1) begin
        l = 2 * pos + 1;
        r = l + 1;
        pick = pos;
        if (l < heap_cnt && slots[l] < slots[pick]) pick = l;
        if (r < heap_cnt && slots[r] < slots[pick]) pick = r;
        if (pick == pos) break;
        t = slots[pos];
        slots[pos] = slots[pick];
        slots[pick] = t;
        pos = pick;
      end
      return top;
    endfunction

    function void put_id(logic [ID_W-1:0] v);
      logic [ID_W-1:0] t;
      int pos, up;
      pos = heap_cnt;
      slots[pos] = v;
      heap_cnt++;
      while (pos != 0) begin
        up = (pos - 1) / 2;
        if (slots[up] > slots[pos]) begin
          t = slots[up];
          slots[up] = slots[pos];
          slots[pos] = t;
          pos = up;
        end else begin
          break;
        end
      end
    endfunction

    // called on every accepted request transfer
    function void note_input(logic rt, logic [ID_W-1:0] rid);
      grant_t g;
      int eff_limit;
      g.id = '0;
      g.st = idalloc_pkg::ST_OK;
      if (rt == REQ_ALLOC) begin
        eff_limit = (limit > HEAP_DEPTH) ? HEAP_DEPTH : limit;
        if (heap_cnt > 0) begin
          g.id = take_min();
        end else if (issued >= eff_limit) begin
          g.st = idalloc_pkg::ST_EXHAUSTED;
        end else begin
          issued++;
          g.id = ID_W'(issued);
        end
      end else begin
        if (rid == 0 || int'(rid) > issued) g.st = idalloc_pkg::ST_INVALID;
        else if (heap_cnt >= HEAP_DEPTH) g.st = idalloc_pkg::ST_HEAP_FULL;
        else put_id(rid);
      end
      pending_grants.insert(pending_grants.size(), g);
    endfunction

    function void check_result(logic [ID_W-1:0] gid, logic [ST_W-1:0] st);
      grant_t g;
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: id %0d status %0d", gid, st);
        return;
      end
      g = pending_grants.pop_front();
      if (gid !== g.id || st !== g.st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected id %0d status %0d, got id %0d status %0d",
                   g.id, g.st, gid, st);
      end
    endfunction

    function int leftover();
      return pending_grants.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [ID_W-1:0] cfg_wr_data;

  idalloc_req_if req_bus ();
  idalloc_rsp_if rsp_bus ();

  id_allocator_min_heap i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (req_bus),
    .out_rsp     (rsp_bus)
  );

  id_pool_scoreboard sb = new();
  int cycle_cnt = 0;
  int stall_asked = 0;
  int stall_served = 0;
  bit send_fast = 0;
  bit take_fast = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_req(input logic rt, input logic [ID_W-1:0] rid);
    int gap;
    if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= rt;
    req_bus.recycled_id <= rid;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_input(rt, rid);
    @(negedge clk);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.leftover() > 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_limit(input logic [ID_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(v);
    @(negedge clk);
  endtask

  task automatic run_mixed(input int n);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_req(REQ_ALLOC, ID_W'($urandom_range(0, 2047)));
      end else if (roll < 88 && sb.issued > 0) begin
        send_req(REQ_RECYCLE, ID_W'($urandom_range(1, sb.issued)));
      end else begin
        case ($urandom_range(0, 2))
          0: send_req(REQ_RECYCLE, '0);
          1: send_req(REQ_RECYCLE, ID_W'(sb.issued + 1));
          default: send_req(REQ_RECYCLE, ID_W'($urandom_range(0, 2047)));
        endcase
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    rsp_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_fast = !take_fast;
      gap = take_fast ? 0 : $urandom_range(0, 18);
      if (stall_asked > stall_served) begin
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_served++;
      end else if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
      sb.check_result(rsp_bus.granted_id, rsp_bus.status);
      @(negedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_ALLOC;
    req_bus.recycled_id = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // limit of zero, nothing issued yet
    set_limit('0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RECYCLE, ID_W'(1));
    send_req(REQ_RECYCLE, '0);

    set_limit(idalloc_pkg::ID_LIMIT_RST);
    repeat (4) send_req(REQ_ALLOC, '0);
    send_req(REQ_RECYCLE, ID_W'(5));
    send_req(REQ_RECYCLE, '0);
    send_req(REQ_RECYCLE, ID_ALL_ONES);
    send_req(REQ_RECYCLE, ID_W'(3));
    send_req(REQ_RECYCLE, ID_W'(1));
    send_req(REQ_RECYCLE, ID_W'(4));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RECYCLE, ID_W'(2));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RECYCLE, ID_W'(5));
    send_req(REQ_ALLOC, ID_ALL_ONES);

    // limit lowered below what was already issued
    set_limit(ID_W'(3));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RECYCLE, ID_W'(5));
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, '0);

    set_limit(ID_W'($urandom_range(16, 48)));
    run_mixed(40);
    set_limit(ID_W'(1));
    run_mixed(20);
    set_limit(ID_W'($urandom_range(200, 700)));
    stall_asked++;
    run_mixed(40);

    // limit above range, fill the heap and pop part of it back
    set_limit(ID_ALL_ONES);
    stall_asked++;
    while (sb.heap_cnt < HEAP_DEPTH)
      send_req(REQ_RECYCLE, ID_W'($urandom_range(1, sb.issued)));
    send_req(REQ_RECYCLE, ID_W'($urandom_range(1, sb.issued)));
    send_req(REQ_RECYCLE, '0);
    send_req(REQ_RECYCLE, ID_W'(sb.issued + 1));
    repeat (20) send_req(REQ_ALLOC, ID_W'($urandom_range(0, 2047)));
    send_req(REQ_RECYCLE, ID_W'(sb.issued));
    send_req(REQ_ALLOC, '0);

    drain();
    if (sb.errors == 0 && sb.leftover() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
